// ----- design/arl_pkg.sv -----
// Package for the address resolving list: sizes, command and status codes,
// entry layout and the write request carried to the entry store.
// No dependencies.
package arl_pkg;

    localparam int LIST_DEPTH = 8;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IW         = CNT_W + 1;

    localparam int ADDR_W = 48;
    localparam int ID_W   = ADDR_W + 1;
    localparam int LIST_W = 7;
    localparam int TO_W   = 12;
    localparam int PAR_W  = 16;

    localparam logic [7:0]       TYPE_INVALID_MASK = 8'hFE;
    localparam logic [PAR_W-1:0] TIMEOUT_MAX       = 16'd3600;
    localparam logic [TO_W-1:0]  TIMEOUT_DEFAULT   = 12'd900;

    // bit positions inside entry flags
    localparam int FLAG_PEER_VALID  = 0;
    localparam int FLAG_LOCAL_VALID = 1;
    localparam int FLAG_KEY_ZERO    = 2;

    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_REMOVE    = 4'd1,
        CMD_CLEAR     = 4'd2,
        CMD_READ_SIZE = 4'd3,
        CMD_RD_PEER   = 4'd4,
        CMD_RD_LOCAL  = 4'd5,
        CMD_SET_EN    = 4'd6,
        CMD_SET_TO    = 4'd7,
        CMD_INSTALL   = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DISALLOWED = 3'd1,
        ST_INVALID    = 3'd2,
        ST_CAPACITY   = 3'd3,
        ST_UNKNOWN    = 3'd4
    } status_t;

    localparam logic [1:0] LINK_ADV  = 2'd1;
    localparam logic [1:0] LINK_SCAN = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   identity;   // type in the top bit
        logic [ADDR_W-1:0] local_addr;
        logic [ADDR_W-1:0] peer_addr;
        logic [2:0]        flags;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

endpackage

// ----- design/arl_store.sv -----
// Entry store of the address resolving list: one write port, one read port
// with registered read data. Depends on arl_pkg.
module arl_store (
    input  logic                        clk,
    input  arl_pkg::wr_req_t            wr,
    input  logic [arl_pkg::IDX_W-1:0]   rd_addr,
    output arl_pkg::entry_t             rd_data
);
    import arl_pkg::*;

    entry_t mem [LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/address_resolving_list_unit.sv -----
// Top level of the address resolving list: command sequencer, shared
// identity comparator and result register. Depends on arl_pkg and arl_store.
// A command is taken when the unit is idle and returns one status
// transaction. Commands that need no lookup go from decode straight to the
// result step; add, remove, the reads and install walk the live entries
// through the single read port of the entry store, with a read and a compare
// state per entry, and remove then moves each later entry down with a read
// and a write state before the result step.
// The input side is not ready until the result is loaded into the output
// register; a result still waiting there lets the next command be taken and
// processed, which then holds in its final step until the register is free.
module address_resolving_list_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // link_state[1:0], address_type[9:2], identity_addr[57:10],
    // peer_key_zero[58], param_value[74:59], install_peer[75],
    // private_address[123:76], zero fill[127:124]
    input  logic [127:0] s_axis_tdata,
    // command[3:0]
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // list_value[6:0], address_out[54:7], resolution_on[55],
    // timeout_seconds[67:56], zero fill[71:68]
    output logic [71:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser
);
    import arl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRD,
        S_SCMP,
        S_SHRD,
        S_SHWR,
        S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         cmd_reg, cmd_next;
    logic [1:0]         link_reg, link_next;
    logic [7:0]         atype_reg, atype_next;
    logic [ADDR_W-1:0]  ident_reg, ident_next;
    logic               keyzero_reg, keyzero_next;
    logic [PAR_W-1:0]   param_reg, param_next;
    logic               to_peer_reg, to_peer_next;
    logic [ADDR_W-1:0]  priv_reg, priv_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               enable_reg, enable_next;
    logic [TO_W-1:0]    timeout_reg, timeout_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               m_valid_reg, m_valid_next;
    status_t            o_status_reg, o_status_next;
    logic [LIST_W-1:0]  o_list_reg, o_list_next;
    logic [ADDR_W-1:0]  o_addr_reg, o_addr_next;
    logic               o_res_reg, o_res_next;
    logic [TO_W-1:0]    o_to_reg, o_to_next;

    wr_req_t            wr;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    logic [ID_W-1:0]    key;
    logic               active;
    logic               locked;
    logic               bad_type;
    logic               match;
    logic               last_cmp;
    logic               last_move;
    logic [IDX_W-1:0]   idx_inc;
    logic [IW-1:0]      count_w;
    logic               list_full;
    entry_t             new_entry;
    entry_t             inst_entry;

    arl_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = o_status_reg;
    assign m_axis_tdata  = {4'd0, o_to_reg, o_res_reg, o_addr_reg, o_list_reg};

    // shared comparator and loop bounds
    assign key       = {atype_reg[0], ident_reg};
    assign active    = (link_reg == LINK_ADV) || (link_reg == LINK_SCAN);
    assign locked    = enable_reg && active;
    assign bad_type  = |(atype_reg & TYPE_INVALID_MASK);
    assign match     = (rd_data.identity == key);
    assign idx_inc   = idx_reg + 1'b1;
    assign count_w   = IW'(count_reg);
    assign last_cmp  = ((IW'(idx_reg) + IW'(1)) == count_w);
    assign last_move = ((IW'(idx_reg) + IW'(2)) == count_w);
    assign list_full = (count_w >= IW'(LIST_DEPTH));
    assign rd_addr   = (state_reg == S_SHRD) ? idx_inc : idx_reg;

    always_comb
    begin
        new_entry.identity   = key;
        new_entry.local_addr = '0;
        new_entry.peer_addr  = '0;
        new_entry.flags      = 3'(keyzero_reg) << FLAG_KEY_ZERO;

        inst_entry = rd_data;
        if (to_peer_reg)
        begin
            inst_entry.peer_addr = rd_data.flags[FLAG_KEY_ZERO] ? ident_reg : priv_reg;
            inst_entry.flags[FLAG_PEER_VALID] = 1'b1;
        end
        else
        begin
            inst_entry.local_addr = priv_reg;
            inst_entry.flags[FLAG_LOCAL_VALID] = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        link_next     = link_reg;
        atype_next    = atype_reg;
        ident_next    = ident_reg;
        keyzero_next  = keyzero_reg;
        param_next    = param_reg;
        to_peer_next  = to_peer_reg;
        priv_next     = priv_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        enable_next   = enable_reg;
        timeout_next  = timeout_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        o_status_next = o_status_reg;
        o_list_next   = o_list_reg;
        o_addr_next   = o_addr_reg;
        o_res_next    = o_res_reg;
        o_to_next     = o_to_reg;
        wr.en         = 1'b0;
        wr.addr       = idx_reg;
        wr.data       = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next     = s_axis_tuser;
                    link_next    = s_axis_tdata[1:0];
                    atype_next   = s_axis_tdata[9:2];
                    ident_next   = s_axis_tdata[57:10];
                    keyzero_next = s_axis_tdata[58];
                    param_next   = s_axis_tdata[74:59];
                    to_peer_next = s_axis_tdata[75];
                    priv_next    = s_axis_tdata[123:76];
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_DISALLOWED;
                addr_next   = '0;
                idx_next    = '0;
                state_next  = S_FIN;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        priority if (locked)
                            status_next = ST_DISALLOWED;
                        else if (bad_type)
                            status_next = ST_INVALID;
                        else if (list_full)
                            status_next = ST_CAPACITY;
                        else if (count_reg == '0)
                        begin
                            wr.en       = 1'b1;
                            wr.addr     = '0;
                            wr.data     = new_entry;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_OK;
                        end
                        else
                            state_next = S_SRD;
                    end
                    CMD_REMOVE:
                    begin
                        priority if (locked)
                            status_next = ST_DISALLOWED;
                        else if (bad_type)
                            status_next = ST_INVALID;
                        else if (count_reg == '0)
                            status_next = ST_UNKNOWN;
                        else
                            state_next = S_SRD;
                    end
                    CMD_CLEAR:
                    begin
                        if (!locked)
                        begin
                            count_next  = '0;
                            status_next = ST_OK;
                        end
                    end
                    CMD_READ_SIZE:
                    begin
                        status_next = ST_OK;
                    end
                    CMD_RD_PEER, CMD_RD_LOCAL, CMD_INSTALL:
                    begin
                        priority if (bad_type)
                            status_next = ST_INVALID;
                        else if (count_reg == '0)
                            status_next = ST_UNKNOWN;
                        else
                            state_next = S_SRD;
                    end
                    CMD_SET_EN:
                    begin
                        priority if (active || (param_reg == PAR_W'(enable_reg)))
                            status_next = ST_DISALLOWED;
                        else if (param_reg[PAR_W-1:1] != '0)
                            status_next = ST_INVALID;
                        else
                        begin
                            enable_next = param_reg[0];
                            status_next = ST_OK;
                        end
                    end
                    CMD_SET_TO:
                    begin
                        if ((param_reg != '0) && (param_reg <= TIMEOUT_MAX))
                        begin
                            timeout_next = param_reg[TO_W-1:0];
                            status_next  = ST_OK;
                        end
                        else
                            status_next = ST_INVALID;
                    end
                    default:
                    begin
                        status_next = ST_DISALLOWED;
                    end
                endcase
            end

            S_SRD:
            begin
                state_next = S_SCMP;
            end

            S_SCMP:
            begin
                state_next = S_FIN;
                if (match)
                begin
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            status_next = ST_INVALID;
                        end
                        CMD_REMOVE:
                        begin
                            if (last_cmp)
                            begin
                                count_next  = count_reg - 1'b1;
                                status_next = ST_OK;
                            end
                            else
                                state_next = S_SHRD;
                        end
                        CMD_RD_PEER:
                        begin
                            if (rd_data.flags[FLAG_PEER_VALID])
                            begin
                                addr_next   = rd_data.peer_addr;
                                status_next = ST_OK;
                            end
                            else
                                status_next = ST_UNKNOWN;
                        end
                        CMD_RD_LOCAL:
                        begin
                            if (rd_data.flags[FLAG_LOCAL_VALID])
                            begin
                                addr_next   = rd_data.local_addr;
                                status_next = ST_OK;
                            end
                            else
                                status_next = ST_UNKNOWN;
                        end
                        default:
                        begin
                            // install writes back the matched entry
                            wr.en       = 1'b1;
                            wr.addr     = idx_reg;
                            wr.data     = inst_entry;
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (last_cmp)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = count_reg[IDX_W-1:0];
                        wr.data     = new_entry;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_OK;
                    end
                    else
                        status_next = ST_UNKNOWN;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRD;
                end
            end

            S_SHRD:
            begin
                state_next = S_SHWR;
            end

            S_SHWR:
            begin
                // move the next entry down one place
                wr.en    = 1'b1;
                wr.addr  = idx_reg;
                wr.data  = rd_data;
                idx_next = idx_inc;
                if (last_move)
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
                else
                    state_next = S_SHRD;
            end

            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_list_next   = (cmd_reg == CMD_READ_SIZE) ? LIST_W'(LIST_DEPTH)
                                                               : LIST_W'(count_reg);
                    o_addr_next   = addr_reg;
                    o_res_next    = enable_reg;
                    o_to_next     = timeout_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            link_reg     <= '0;
            atype_reg    <= '0;
            ident_reg    <= '0;
            keyzero_reg  <= 1'b0;
            param_reg    <= '0;
            to_peer_reg  <= 1'b0;
            priv_reg     <= '0;
            idx_reg      <= '0;
            count_reg    <= '0;
            enable_reg   <= 1'b0;
            timeout_reg  <= TIMEOUT_DEFAULT;
            status_reg   <= ST_OK;
            addr_reg     <= '0;
            m_valid_reg  <= 1'b0;
            o_status_reg <= ST_OK;
            o_list_reg   <= '0;
            o_addr_reg   <= '0;
            o_res_reg    <= 1'b0;
            o_to_reg     <= TIMEOUT_DEFAULT;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            link_reg     <= link_next;
            atype_reg    <= atype_next;
            ident_reg    <= ident_next;
            keyzero_reg  <= keyzero_next;
            param_reg    <= param_next;
            to_peer_reg  <= to_peer_next;
            priv_reg     <= priv_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            enable_reg   <= enable_next;
            timeout_reg  <= timeout_next;
            status_reg   <= status_next;
            addr_reg     <= addr_next;
            m_valid_reg  <= m_valid_next;
            o_status_reg <= o_status_next;
            o_list_reg   <= o_list_next;
            o_addr_reg   <= o_addr_next;
            o_res_reg    <= o_res_next;
            o_to_reg     <= o_to_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= IW'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again while a command is in progress");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg != S_IDLE) && (state_reg != S_FIN))
        else $error("entry store written outside command processing");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_w == IW'($past(count_reg)) + IW'(1)) ||
             (IW'(count_reg) + IW'(1) == IW'($past(count_reg))) ||
             (count_reg == '0)))
        else $error("entry count moved by more than one");

endmodule
